// File: hw/rtl/srsm_pkg.sv
// Shared widths, codes and controller/datapath interface types of the striped range segment mapper.
package srsm_pkg;

	localparam int FILE_W     = 3;
	localparam int UNIT_W     = 8;
	localparam int VAL_W      = 48;
	localparam int REL_W      = 40;
	localparam int LEN_W      = 40;
	localparam int OFF_W      = 48;
	localparam int CNT_W      = 24;
	localparam int FC_W       = 4;
	localparam int PAGE_SHIFT = 12;
	localparam int TOT_W      = CNT_W + FILE_W;
	localparam int PG_W       = OFF_W - PAGE_SHIFT;
	localparam int SPG_W      = REL_W - PAGE_SHIFT;
	localparam int EPG_W      = REL_W + 1 - PAGE_SHIFT + 1;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [1:0] ACT_LOAD_PAGES = 2'd0;
	localparam logic [1:0] ACT_LOAD_BASE  = 2'd1;
	localparam logic [1:0] ACT_TRANSLATE  = 2'd2;

	localparam logic [0:0] REG_FILE_COUNT = 1'b0;

	typedef struct packed {
		logic clr;
		logic capture;
		logic base_wr;
		logic ld_old;
		logic ld_delta;
		logic sweep;
		logic gather;
		logic walk;
		logic single;
		logic single_err;
	} srsm_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic ld_ok;
		logic len_zero;
		logic sweep_end;
		logic gather_end;
		logic walk_end;
		logic past;
		logic a_hit;
		logic a_last;
		logic out_free;
	} srsm_sts_t;

endpackage

// File: hw/rtl/srsm_ram.sv
// Generic RAM with one write port and two registered read ports.
module srsm_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 2048,
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] ra_addr,
	output logic [WIDTH-1:0]  ra_data,
	input  logic [ADDR_W-1:0] rb_addr,
	output logic [WIDTH-1:0]  rb_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		ra_data <= mem[ra_addr];
		rb_data <= mem[rb_addr];
	end

endmodule

// File: hw/rtl/srsm_dp.sv
// Datapath of the segment mapper: prefix-sum table, per-file gather registers and segment pipeline.
module srsm_dp #(
	parameter int FILES = 8,
	parameter int UNITS = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srsm_pkg::srsm_cmd_t            cmd,
	output srsm_pkg::srsm_sts_t            sts,
	input  logic [srsm_pkg::FC_W-1:0]      file_count,
	input  logic [srsm_pkg::FILE_W-1:0]    file_index,
	input  logic [srsm_pkg::UNIT_W-1:0]    unit_index,
	input  logic [srsm_pkg::VAL_W-1:0]     load_value,
	input  logic [srsm_pkg::REL_W-1:0]     rel_offset,
	input  logic [srsm_pkg::LEN_W-1:0]     interval_length,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [srsm_pkg::FILE_W-1:0]    seg_file,
	output logic [srsm_pkg::OFF_W-1:0]     seg_offset,
	output logic [srsm_pkg::LEN_W-1:0]     seg_length,
	output logic [srsm_pkg::REL_W-1:0]     dest_offset,
	output logic                           past_coverage,
	output logic                           last
);

	localparam int FW    = (FILES > 1) ? $clog2(FILES) : 1;
	localparam int UW    = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int SW    = srsm_pkg::CNT_W + $clog2(UNITS);
	localparam int AW    = FW + UW;
	localparam int DEPTH = FILES * (2 ** UW);
	localparam int PS    = srsm_pkg::PAGE_SHIFT;
	localparam int EBW   = srsm_pkg::REL_W + 1;

	localparam logic [srsm_pkg::FC_W-1:0] FILES_L = srsm_pkg::FC_W'(FILES);
	localparam logic [UW-1:0]             U_LAST  = UW'(UNITS - 1);

	// Prefix-sum memory and its ports.
	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;
	logic [AW-1:0] ra_addr;
	logic [AW-1:0] rb_addr;
	logic [SW-1:0] rda;
	logic [SW-1:0] rdb;

	// Control registers.
	logic [AW-1:0] clr_cnt_q;
	logic [UW-1:0] k_q;
	logic [FW-1:0] g_q;
	logic [FW-1:0] w_q;
	logic          sw_v_s1;
	logic          rd_v_s1;
	logic          g2_v_s2;
	logic          wk_v_s1;
	logic          out_valid_q;
	logic [srsm_pkg::OFF_W-1:0] base_q [FILES];

	// Payload registers.
	logic [srsm_pkg::FILE_W-1:0] file_q;
	logic [UW-1:0]               hi_u_q;
	logic [UW-1:0]               lo_u_q;
	logic                        lo_zero_q;
	logic [srsm_pkg::CNT_W-1:0]  val_q;
	logic [srsm_pkg::REL_W-1:0]  rel_q;
	logic [srsm_pkg::LEN_W-1:0]  len_q;
	logic [EBW-1:0]              endb_q;
	logic [srsm_pkg::EPG_W-1:0]  end_pg_q;
	logic [SW-1:0]               old_q;
	logic [SW-1:0]               delta_q;
	logic [AW-1:0]               sw_a_s1;
	logic [FW-1:0]               rd_f_s1;
	logic [FW-1:0]               g2_f_s2;
	logic [srsm_pkg::CNT_W-1:0]  cnt_s2;
	logic [SW-1:0]               pre_s2;
	logic [srsm_pkg::TOT_W-1:0]  total_q;
	logic [SW-1:0]               pre_q    [FILES];
	logic [srsm_pkg::TOT_W-1:0]  cum_q    [FILES];
	logic [srsm_pkg::TOT_W-1:0]  cumend_q [FILES];
	logic [srsm_pkg::PG_W-1:0]   pmc_q    [FILES];
	logic [FW-1:0]               f_s1;
	logic                        first_s1;
	logic                        last_s1;
	logic [srsm_pkg::PG_W-1:0]   pg_s1;
	logic [srsm_pkg::REL_W-1:0]  s0_s1;
	logic [EBW-1:0]              s1_s1;

	// Combinational terms.
	logic [srsm_pkg::FC_W-1:0]   n_files;
	logic [srsm_pkg::FC_W-1:0]   n_last;
	logic                        beyond;
	logic [srsm_pkg::UNIT_W-1:0] unit_m1;
	logic                        base_ok;
	logic                        out_free;
	logic [FW-1:0]               rsel;
	logic [SW-1:0]               pre_now;
	logic [SW-1:0]               cnt_now;
	logic [srsm_pkg::TOT_W-1:0]  total_nx;
	logic [srsm_pkg::SPG_W-1:0]  start_pg;
	logic [srsm_pkg::EPG_W-1:0]  spg_e;
	logic [srsm_pkg::EPG_W-1:0]  cum_e;
	logic [srsm_pkg::EPG_W-1:0]  ce_e;
	logic                        a_hit;
	logic                        a_first;
	logic                        a_last;
	logic [srsm_pkg::PG_W-1:0]   a_pg;
	logic [srsm_pkg::REL_W-1:0]  a_s0;
	logic [EBW-1:0]              a_s1;

	always_comb begin
		if (file_count == '0) begin
			n_files = srsm_pkg::FC_W'(1);
		end else if (file_count > FILES_L) begin
			n_files = FILES_L;
		end else begin
			n_files = file_count;
		end
	end

	assign n_last  = n_files - srsm_pkg::FC_W'(1);
	assign beyond  = {1'b0, unit_index} >= 9'(UNITS);
	assign unit_m1 = unit_index - srsm_pkg::UNIT_W'(1);
	assign base_ok = {1'b0, file_index} < srsm_pkg::FC_W'(FILES);
	assign out_free = !out_valid_q || !out_stall;

	assign rsel    = cmd.gather ? g_q : file_q[FW-1:0];
	assign ra_addr = cmd.sweep ? {file_q[FW-1:0], k_q} : {rsel, hi_u_q};
	assign rb_addr = {rsel, lo_u_q};
	assign we      = cmd.clr || sw_v_s1;
	assign waddr   = cmd.clr ? clr_cnt_q : sw_a_s1;
	assign wdata   = cmd.clr ? '0 : rda + delta_q;

	assign pre_now  = lo_zero_q ? '0 : rdb;
	assign cnt_now  = rda - pre_now;
	assign total_nx = total_q + srsm_pkg::TOT_W'(cnt_s2);

	assign start_pg = rel_q[srsm_pkg::REL_W-1:PS];
	assign spg_e    = srsm_pkg::EPG_W'(start_pg);
	assign cum_e    = srsm_pkg::EPG_W'(cum_q[w_q]);
	assign ce_e     = srsm_pkg::EPG_W'(cumend_q[w_q]);
	assign a_hit    = (ce_e != cum_e) && (spg_e < ce_e) && (cum_e < end_pg_q);
	assign a_first  = cum_e <= spg_e;
	assign a_last   = end_pg_q <= ce_e;
	assign a_pg     = a_first ? pmc_q[w_q] + srsm_pkg::PG_W'(start_pg)
	                          : srsm_pkg::PG_W'(pre_q[w_q]);
	assign a_s0     = a_first ? rel_q : srsm_pkg::REL_W'({cum_q[w_q], {PS{1'b0}}});
	assign a_s1     = a_last ? endb_q : EBW'({cumend_q[w_q], {PS{1'b0}}});

	assign sts.clr_done   = clr_cnt_q == AW'(DEPTH - 1);
	assign sts.ld_ok      = base_ok && !beyond;
	assign sts.len_zero   = interval_length == '0;
	assign sts.sweep_end  = k_q == U_LAST;
	assign sts.gather_end = srsm_pkg::FC_W'(g_q) == n_last;
	assign sts.walk_end   = srsm_pkg::FC_W'(w_q) == n_last;
	assign sts.past       = end_pg_q > srsm_pkg::EPG_W'(total_q);
	assign sts.a_hit      = a_hit;
	assign sts.a_last     = a_last;
	assign sts.out_free   = out_free;

	assign out_valid = out_valid_q;

	srsm_ram #(
		.WIDTH  (SW),
		.DEPTH  (DEPTH),
		.ADDR_W (AW)
	) u_prefix_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.ra_addr (ra_addr),
		.ra_data (rda),
		.rb_addr (rb_addr),
		.rb_data (rdb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			k_q         <= '0;
			g_q         <= '0;
			w_q         <= '0;
			sw_v_s1     <= 1'b0;
			rd_v_s1     <= 1'b0;
			g2_v_s2     <= 1'b0;
			wk_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < FILES; i++) begin
				base_q[i] <= '0;
			end
		end else begin
			if (cmd.clr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.base_wr && base_ok) begin
				base_q[file_index[FW-1:0]] <= load_value;
			end
			if (cmd.capture) begin
				g_q <= '0;
				w_q <= '0;
				k_q <= beyond ? U_LAST : unit_index[UW-1:0];
			end else begin
				if (cmd.sweep) begin
					k_q <= k_q + UW'(1);
				end
				if (cmd.gather) begin
					g_q <= g_q + FW'(1);
				end
				if (cmd.walk) begin
					w_q <= w_q + FW'(1);
				end
			end
			sw_v_s1 <= cmd.sweep;
			rd_v_s1 <= cmd.gather;
			g2_v_s2 <= rd_v_s1;
			if (out_free) begin
				wk_v_s1     <= cmd.walk && a_hit;
				out_valid_q <= wk_v_s1 || cmd.single;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			file_q    <= file_index;
			hi_u_q    <= beyond ? U_LAST : unit_index[UW-1:0];
			lo_u_q    <= beyond ? U_LAST : unit_m1[UW-1:0];
			lo_zero_q <= !beyond && (unit_index == '0);
			val_q     <= load_value[srsm_pkg::CNT_W-1:0];
			rel_q     <= rel_offset;
			len_q     <= interval_length;
			total_q   <= '0;
		end else if (g2_v_s2) begin
			total_q <= total_nx;
		end
		endb_q   <= {1'b0, rel_q} + {1'b0, len_q};
		end_pg_q <= srsm_pkg::EPG_W'(endb_q[EBW-1:PS]) + srsm_pkg::EPG_W'(|endb_q[PS-1:0]);
		if (cmd.ld_old) begin
			old_q <= cnt_now;
		end
		if (cmd.ld_delta) begin
			delta_q <= SW'(val_q) - old_q;
		end
		if (cmd.sweep) begin
			sw_a_s1 <= {file_q[FW-1:0], k_q};
		end
		if (cmd.gather) begin
			rd_f_s1 <= g_q;
		end
		if (rd_v_s1) begin
			pre_q[rd_f_s1] <= pre_now;
			g2_f_s2        <= rd_f_s1;
			cnt_s2         <= cnt_now[srsm_pkg::CNT_W-1:0];
			pre_s2         <= pre_now;
		end
		if (g2_v_s2) begin
			cum_q[g2_f_s2]    <= total_q;
			cumend_q[g2_f_s2] <= total_nx;
			pmc_q[g2_f_s2]    <= srsm_pkg::PG_W'(pre_s2) - srsm_pkg::PG_W'(total_q);
		end
		if (cmd.walk && out_free) begin
			f_s1     <= w_q;
			first_s1 <= a_first;
			last_s1  <= a_last;
			pg_s1    <= a_pg;
			s0_s1    <= a_s0;
			s1_s1    <= a_s1;
		end
		if (out_free) begin
			if (wk_v_s1) begin
				seg_file      <= srsm_pkg::FILE_W'(f_s1);
				seg_offset    <= base_q[f_s1]
				                 + {pg_s1, first_s1 ? rel_q[PS-1:0] : {PS{1'b0}}};
				seg_length    <= srsm_pkg::LEN_W'(s1_s1 - EBW'(s0_s1));
				dest_offset   <= s0_s1 - rel_q;
				past_coverage <= 1'b0;
				last          <= last_s1;
			end else if (cmd.single) begin
				seg_file      <= '0;
				seg_offset    <= '0;
				seg_length    <= '0;
				dest_offset   <= '0;
				past_coverage <= cmd.single_err;
				last          <= 1'b1;
			end
		end
	end

endmodule

// File: hw/rtl/srsm_ctrl.sv
// Controller state machine of the segment mapper: clearing pass, loads and translate sequencing.
module srsm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           action,
	input  srsm_pkg::srsm_sts_t  sts,
	output srsm_pkg::srsm_cmd_t  cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_RD,
		ST_LD_OLD,
		ST_LD_DELTA,
		ST_LD_SWEEP,
		ST_LD_FLUSH,
		ST_TR_GATHER,
		ST_TR_W1,
		ST_TR_W2,
		ST_TR_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_OUT_EMPTY,
		ST_OUT_PAST
	} state_t;

	state_t state_q;
	logic   acc;

	assign in_stall = state_q != ST_IDLE;
	assign acc      = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.capture    = acc;
		cmd.base_wr    = acc && (action == srsm_pkg::ACT_LOAD_BASE);
		cmd.clr        = state_q == ST_CLEAR;
		cmd.ld_old     = state_q == ST_LD_OLD;
		cmd.ld_delta   = state_q == ST_LD_DELTA;
		cmd.sweep      = state_q == ST_LD_SWEEP;
		cmd.gather     = state_q == ST_TR_GATHER;
		cmd.walk       = (state_q == ST_WALK) && sts.out_free;
		cmd.single     = ((state_q == ST_OUT_EMPTY) || (state_q == ST_OUT_PAST)) && sts.out_free;
		cmd.single_err = state_q == ST_OUT_PAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (action)
							srsm_pkg::ACT_LOAD_PAGES: begin
								state_q <= sts.ld_ok ? ST_LD_RD : ST_IDLE;
							end
							srsm_pkg::ACT_TRANSLATE: begin
								state_q <= sts.len_zero ? ST_OUT_EMPTY : ST_TR_GATHER;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_LD_RD: begin
					state_q <= ST_LD_OLD;
				end
				ST_LD_OLD: begin
					state_q <= ST_LD_DELTA;
				end
				ST_LD_DELTA: begin
					state_q <= ST_LD_SWEEP;
				end
				ST_LD_SWEEP: begin
					if (sts.sweep_end) begin
						state_q <= ST_LD_FLUSH;
					end
				end
				ST_LD_FLUSH: begin
					state_q <= ST_IDLE;
				end
				ST_TR_GATHER: begin
					if (sts.gather_end) begin
						state_q <= ST_TR_W1;
					end
				end
				ST_TR_W1: begin
					state_q <= ST_TR_W2;
				end
				ST_TR_W2: begin
					state_q <= ST_TR_DECIDE;
				end
				ST_TR_DECIDE: begin
					state_q <= sts.past ? ST_OUT_PAST : ST_WALK;
				end
				ST_WALK: begin
					if (sts.out_free && ((sts.a_hit && sts.a_last) || sts.walk_end)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT_EMPTY, ST_OUT_PAST: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/striped_range_segment_mapper.sv
// Top level of the striped range segment mapper: configuration register, controller and datapath.
//
// The block takes one request at a time. Page counts are held as running sums per file in one
// memory, so a translate reads two sums per file in use: it gathers the counts with one memory
// read per file and then walks the files to emit the segments, waiting while the output is
// stalled, and stops early when the interval ends in an early file. A page-count load rewrites
// the running sums of that unit and every later unit of that file, one memory entry a cycle;
// a base-offset load is written as it is accepted. After reset a clearing pass zeroes all of
// the memory, MAX_FILES times MAX_UNITS entries (capped at 8 and 256, units rounded up to a
// power of two), 2048 by default, while no request is taken; configuration writes are
// accepted throughout. A finished segment waits in the output register while the next
// request is accepted.
module striped_range_segment_mapper #(
	parameter int MAX_FILES = 8,
	parameter int MAX_UNITS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srsm_pkg::APB_AW-1:0]   paddr,
	input  logic [srsm_pkg::APB_DW-1:0]   pwdata,
	output logic [srsm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    action,
	input  logic [srsm_pkg::FILE_W-1:0]   file_index,
	input  logic [srsm_pkg::UNIT_W-1:0]   unit_index,
	input  logic [srsm_pkg::VAL_W-1:0]    load_value,
	input  logic [srsm_pkg::REL_W-1:0]    rel_offset,
	input  logic [srsm_pkg::LEN_W-1:0]    interval_length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [srsm_pkg::FILE_W-1:0]   seg_file,
	output logic [srsm_pkg::OFF_W-1:0]    seg_offset,
	output logic [srsm_pkg::LEN_W-1:0]    seg_length,
	output logic [srsm_pkg::REL_W-1:0]    dest_offset,
	output logic                          past_coverage,
	output logic                          last
);

	localparam int FILES = (MAX_FILES < 8) ? MAX_FILES : 8;
	localparam int UNITS = (MAX_UNITS < 256) ? MAX_UNITS : 256;

	logic [srsm_pkg::FC_W-1:0] file_count_q;
	logic                      reg_hit;
	srsm_pkg::srsm_cmd_t       cmd;
	srsm_pkg::srsm_sts_t       sts;

	assign pready  = 1'b1;
	assign reg_hit = paddr[2:2] == srsm_pkg::REG_FILE_COUNT;
	assign prdata  = reg_hit ? srsm_pkg::APB_DW'(file_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_count_q <= srsm_pkg::FC_W'(1);
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			file_count_q <= pwdata[srsm_pkg::FC_W-1:0];
		end
	end

	srsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	srsm_dp #(
		.FILES (FILES),
		.UNITS (UNITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.file_count      (file_count_q),
		.file_index      (file_index),
		.unit_index      (unit_index),
		.load_value      (load_value),
		.rel_offset      (rel_offset),
		.interval_length (interval_length),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.seg_file        (seg_file),
		.seg_offset      (seg_offset),
		.seg_length      (seg_length),
		.dest_offset     (dest_offset),
		.past_coverage   (past_coverage),
		.last            (last)
	);

endmodule

// File: sim/striped_range_segment_mapper_tb.sv
// Self-checking testbench of the striped range segment mapper against a predictor.
module striped_range_segment_mapper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int APB_AW = srsm_pkg::APB_AW;
	localparam int APB_DW = srsm_pkg::APB_DW;
	localparam int FILE_W = srsm_pkg::FILE_W;
	localparam int UNIT_W = srsm_pkg::UNIT_W;
	localparam int VAL_W  = srsm_pkg::VAL_W;
	localparam int REL_W  = srsm_pkg::REL_W;
	localparam int LEN_W  = srsm_pkg::LEN_W;
	localparam int OFF_W  = srsm_pkg::OFF_W;
	localparam int CNT_W  = srsm_pkg::CNT_W;
	localparam int FC_W   = srsm_pkg::FC_W;

	localparam int NFILES = 8;
	localparam int NUNITS = 256;
	localparam longint unsigned PAGE_BYTES = 4096;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam logic [APB_AW-1:0] FILE_COUNT_ADDR = APB_AW'(4 * srsm_pkg::REG_FILE_COUNT);
	localparam int SETTLE_CYCLES = 300;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int PHASES = 7;
	localparam int PHASE_REQUESTS = 27;

	typedef struct packed {
		logic [1:0]        act;
		logic [FILE_W-1:0] file;
		logic [UNIT_W-1:0] unit;
		logic [VAL_W-1:0]  value;
		logic [REL_W-1:0]  rel;
		logic [LEN_W-1:0]  len;
	} request_t;

	typedef struct packed {
		logic [FILE_W-1:0] file;
		logic [OFF_W-1:0]  offset;
		logic [LEN_W-1:0]  length;
		logic [REL_W-1:0]  dest;
		logic              past;
		logic              fin;
	} segment_t;

	typedef struct packed {
		request_t rq;
		logic     is_setting;
		logic     typed;
		segment_t seg;
	} step_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [FILE_W-1:0] file_index;
	logic [UNIT_W-1:0] unit_index;
	logic [VAL_W-1:0] load_value;
	logic [REL_W-1:0] rel_offset;
	logic [LEN_W-1:0] interval_length;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FILE_W-1:0] seg_file;
	logic [OFF_W-1:0] seg_offset;
	logic [LEN_W-1:0] seg_length;
	logic [REL_W-1:0] dest_offset;
	logic past_coverage;
	logic last;

	logic [CNT_W-1:0] page_counts [NFILES][NUNITS];
	logic [OFF_W-1:0] file_bases [NFILES];
	logic [FC_W-1:0] file_count_reg;
	logic [FC_W-1:0] phase_fc [PHASES];
	segment_t segments_due [$];
	step_t directed [$];

	int cycles = 0;
	int mismatches = 0;
	int results_seen = 0;
	int n_requests = 0;
	int n_translates = 0;
	int holds_asked = 0;
	int holds_taken = 0;
	int hold_left = 0;
	bit quiet_mode = 1'b0;

	striped_range_segment_mapper dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d segments outstanding.", cycles,
				segments_due.size());
			$display("striped_range_segment_mapper_tb NOT OK");
			$finish;
		end
	end

	function automatic void report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= SHOWN_MISMATCHES) $display("%s", msg);
	endfunction

	function automatic string seg_text(input segment_t s);
		return $sformatf("file %0d offset 0x%h length 0x%h dest 0x%h past %b last %b",
			s.file, s.offset, s.length, s.dest, s.past, s.fin);
	endfunction

	function automatic int files_in_use();
		if (file_count_reg == 0) return 1;
		if (file_count_reg > NFILES) return NFILES;
		return int'(file_count_reg);
	endfunction

	function automatic void predict_segments(input logic [UNIT_W-1:0] unit,
			input logic [REL_W-1:0] rel, input logic [LEN_W-1:0] len);
		longint unsigned cnt [NFILES];
		longint unsigned pre [NFILES];
		longint unsigned cum [NFILES];
		longint unsigned total, cur, end_pg, avail, local_pg, s0, s1, r, l;
		int n, fi, nseg;
		segment_t seg;
		n = files_in_use();
		r = rel;
		l = len;
		total = 0;
		seg = '0;
		for (int i = 0; i < n; i++) begin
			pre[i] = 0;
			for (int k = 0; k < int'(unit); k++) pre[i] += page_counts[i][k];
			cnt[i] = page_counts[i][unit];
			cum[i] = total;
			total += cnt[i];
		end
		if (l == 0) begin
			seg.fin = 1'b1;
			segments_due = {segments_due, seg};
			return;
		end
		cur = r / PAGE_BYTES;
		end_pg = (r + l + PAGE_BYTES - 1) / PAGE_BYTES;
		if (end_pg > total) begin
			seg.past = 1'b1;
			seg.fin = 1'b1;
			segments_due = {segments_due, seg};
			return;
		end
		nseg = 0;
		while (cur < end_pg && nseg < n) begin
			fi = 0;
			while (fi + 1 < n && cur >= cum[fi] + cnt[fi]) fi++;
			local_pg = cur - cum[fi];
			avail = cnt[fi] - local_pg;
			if (end_pg - cur < avail) avail = end_pg - cur;
			s0 = cur * PAGE_BYTES;
			if (r > s0) s0 = r;
			s1 = (cur + avail) * PAGE_BYTES;
			if (r + l < s1) s1 = r + l;
			seg.file = FILE_W'(fi);
			seg.offset = OFF_W'(file_bases[fi] + (pre[fi] + local_pg) * PAGE_BYTES
				+ (s0 - cur * PAGE_BYTES));
			seg.length = LEN_W'(s1 - s0);
			seg.dest = REL_W'(s0 - r);
			seg.past = 1'b0;
			seg.fin = (cur + avail >= end_pg) || (nseg + 1 >= n);
			segments_due = {segments_due, seg};
			nseg++;
			cur += avail;
		end
	endfunction

	function automatic void apply_request(input request_t rq);
		case (rq.act)
			srsm_pkg::ACT_LOAD_PAGES: page_counts[rq.file][rq.unit] = rq.value[CNT_W-1:0];
			srsm_pkg::ACT_LOAD_BASE:  file_bases[rq.file] = rq.value;
			srsm_pkg::ACT_TRANSLATE:  predict_segments(rq.unit, rq.rel, rq.len);
			default: ;
		endcase
	endfunction

	function automatic logic [UNIT_W-1:0] pick_unit();
		int k;
		k = $urandom_range(7);
		if (k < 4) return UNIT_W'(k);
		if (k < 6) return UNIT_W'(250 + k);
		return UNIT_W'($urandom_range(NUNITS - 1));
	endfunction

	function automatic request_t random_request();
		request_t rq;
		longint unsigned total, span, r;
		int pick, sel;
		pick = $urandom_range(99);
		sel = $urandom_range(99);
		total = 0;
		rq.file = FILE_W'($urandom_range(NFILES - 1));
		rq.unit = pick_unit();
		rq.value = VAL_W'({$urandom, $urandom});
		rq.rel = REL_W'({$urandom, $urandom} >> $urandom_range(40));
		rq.len = LEN_W'({$urandom, $urandom} >> $urandom_range(40));
		if (pick < 3) begin
			rq.act = ACT_UNUSED;
			return rq;
		end
		if (pick < 28) begin
			rq.act = srsm_pkg::ACT_LOAD_PAGES;
			if (sel < 65) rq.value = VAL_W'($urandom_range(6));
			else if (sel < 85) rq.value = VAL_W'($urandom_range(32'hFF_FFFF));
			return rq;
		end
		if (pick < 36) begin
			rq.act = srsm_pkg::ACT_LOAD_BASE;
			return rq;
		end
		rq.act = srsm_pkg::ACT_TRANSLATE;
		for (int i = 0; i < files_in_use(); i++) total += page_counts[i][rq.unit];
		span = total * PAGE_BYTES;
		if (sel < 8) begin
			rq.len = '0;
		end else if (sel >= 18 && span != 0) begin
			r = {$urandom, $urandom} % span;
			rq.rel = REL_W'(r);
			if (sel < 28) rq.len = LEN_W'(span - r);
			else if (sel < 34) rq.len = LEN_W'(span - r + 1);
			else rq.len = LEN_W'(1 + {$urandom, $urandom} % (span - r));
		end
		return rq;
	endfunction

	function automatic void add_step(input logic [1:0] act, input int f, input int u,
			input logic [VAL_W-1:0] v, input logic [REL_W-1:0] r, input logic [LEN_W-1:0] l);
		step_t st;
		st = '0;
		st.rq.act = act;
		st.rq.file = FILE_W'(f);
		st.rq.unit = UNIT_W'(u);
		st.rq.value = v;
		st.rq.rel = r;
		st.rq.len = l;
		directed = {directed, st};
	endfunction

	function automatic void add_setting(input logic [FC_W-1:0] fc);
		step_t st;
		st = '0;
		st.is_setting = 1'b1;
		st.rq.value = VAL_W'(fc);
		directed = {directed, st};
	endfunction

	function automatic void typed_result(input int f, input logic [OFF_W-1:0] off,
			input logic [LEN_W-1:0] l, input logic [REL_W-1:0] d, input bit past, input bit fin);
		step_t st;
		st = directed.pop_back();
		st.typed = 1'b1;
		st.seg.file = FILE_W'(f);
		st.seg.offset = off;
		st.seg.length = l;
		st.seg.dest = d;
		st.seg.past = past;
		st.seg.fin = fin;
		directed = {directed, st};
	endfunction

	always @(negedge clk) begin
		if (holds_taken != holds_asked) begin
			holds_taken = holds_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet_mode && ($urandom_range(99) < 11);
		end
	end

	always @(posedge clk) begin
		segment_t got;
		segment_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {seg_file, seg_offset, seg_length, dest_offset, past_coverage, last};
			results_seen++;
			if (segments_due.size() == 0) begin
				report_mismatch({"Segment with no request outstanding: ", seg_text(got)});
			end else begin
				want = segments_due.pop_front();
				if (got !== want)
					report_mismatch($sformatf("Segment %0d differs:\n  wanted %s\n  got    %s",
						results_seen, seg_text(want), seg_text(got)));
			end
		end
	end

	task automatic input_gaps();
		while (!quiet_mode && $urandom_range(99) < 11) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	task automatic send_request(input request_t rq, input bit typed, input segment_t typed_seg);
		@(negedge clk);
		in_valid <= 1'b1;
		action <= rq.act;
		file_index <= rq.file;
		unit_index <= rq.unit;
		load_value <= rq.value;
		rel_offset <= rq.rel;
		interval_length <= rq.len;
		do @(posedge clk); while (in_stall !== 1'b0);
		n_requests++;
		if (rq.act == srsm_pkg::ACT_TRANSLATE) n_translates++;
		if (typed) segments_due = {segments_due, typed_seg};
		else apply_request(rq);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (segments_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_file_count(input logic [FC_W-1:0] fc);
		wait_drained();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= FILE_COUNT_ADDR;
		pwdata <= APB_DW'(fc);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		file_count_reg = fc;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (prdata !== APB_DW'(fc))
			report_mismatch($sformatf("File count reads back 0x%h, wanted 0x%h", prdata, fc));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin
		request_t rq;
		int counted;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		action = ACT_UNUSED;
		file_index = '0;
		unit_index = '0;
		load_value = '0;
		rel_offset = '0;
		interval_length = '0;
		file_count_reg = 4'd1;
		for (int f = 0; f < NFILES; f++) begin
			file_bases[f] = '0;
			for (int u = 0; u < NUNITS; u++) page_counts[f][u] = '0;
		end

		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, '0, '0);
		typed_result(0, '0, '0, '0, 1'b0, 1'b1);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		typed_result(0, '0, '0, '0, 1'b1, 1'b1);
		add_step(ACT_UNUSED, 7, 255, 48'hFFFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF);
		add_step(srsm_pkg::ACT_LOAD_PAGES, 0, 0, 48'hFFFF_FFFF_FFFF, '0, '0);
		add_step(srsm_pkg::ACT_LOAD_BASE, 0, 0, 48'hFFFF_FFFF_FFFF, '0, '0);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, '0, 40'd1);
		typed_result(0, 48'hFFFF_FFFF_FFFF, 40'd1, '0, 1'b0, 1'b1);
		add_step(srsm_pkg::ACT_LOAD_PAGES, 1, 0, 48'd3, '0, '0);
		add_step(srsm_pkg::ACT_LOAD_PAGES, 2, 0, 48'd2, '0, '0);
		add_step(srsm_pkg::ACT_LOAD_PAGES, 7, 255, 48'd5, '0, '0);
		add_setting(4'd8);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, 40'hF_FFFF_EFF6, 40'h4000);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 255, '0, '0, 40'h5000);
		add_step(srsm_pkg::ACT_LOAD_BASE, 7, 0, 48'h1234_5678_9ABC, '0, '0);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 255, '0, 40'h4FFF, 40'd1);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 255, '0, 40'h4FFF, 40'd2);
		typed_result(0, '0, '0, '0, 1'b1, 1'b1);
		add_setting(4'd0);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, 40'hF_FFFF_F000, 40'd1);
		typed_result(0, '0, '0, '0, 1'b1, 1'b1);
		add_setting(4'd15);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, 40'hF_FFFF_F000, 40'd1);
		add_step(srsm_pkg::ACT_LOAD_PAGES, 3, 10, 48'hFFFF_FF00_0000, '0, '0);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 10, '0, '0, 40'd1);
		typed_result(0, '0, '0, '0, 1'b1, 1'b1);
		add_setting(4'd9);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, '0, 40'h10_0000_4000);
		add_step(srsm_pkg::ACT_TRANSLATE, 0, 0, '0, 40'hFF_FFFF_FFFF, '0);
		typed_result(0, '0, '0, '0, 1'b0, 1'b1);

		phase_fc = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd2, 4'd8};
		phase_fc[PHASES - 1] = FC_W'($urandom_range(15));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_setting) begin
				write_file_count(directed[i].rq.value[FC_W-1:0]);
			end else begin
				input_gaps();
				send_request(directed[i].rq, directed[i].typed, directed[i].seg);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			write_file_count(phase_fc[ph]);
			quiet_mode = (ph == 1);
			counted = 0;
			for (int k = 0; counted < PHASE_REQUESTS; k++) begin
				if (ph == 0 && k == 10) holds_asked++;
				if (ph == 2 && k == 15) wait_drained();
				input_gaps();
				rq = random_request();
				send_request(rq, 1'b0, '0);
				if (rq.act != ACT_UNUSED) counted++;
			end
		end
		quiet_mode = 1'b0;

		wait_drained();
		$display("Ran %0d requests, %0d of them translates, over file counts from 0 to 15.",
			n_requests, n_translates);
		$display("Checked %0d segments, with one long output hold-off; %0d mismatches.",
			results_seen, mismatches);
		if (mismatches == 0) begin
			$display("striped_range_segment_mapper_tb OK");
		end else begin
			$display("striped_range_segment_mapper_tb NOT OK");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/srsm_pkg.sv
hw/rtl/srsm_ram.sv
hw/rtl/srsm_dp.sv
hw/rtl/srsm_ctrl.sv
hw/rtl/striped_range_segment_mapper.sv
sim/striped_range_segment_mapper_tb.sv
